// ===== rtl/mcbf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcbf_pkg
// Shared types, constants and the fade curve of the MIDI clock beat LED fader.
// ----------------------------------------------------------------------------
package mcbf_pkg;

  // Number of fade curve steps that an LED walks through before it holds.
  localparam int unsigned CURVE_DEPTH = 50;
  localparam logic [5:0] FADE_LAST = 6'(CURVE_DEPTH - 1);

  // MIDI real-time status bytes.
  localparam logic [7:0] BYTE_CLOCK = 8'hF8;
  localparam logic [7:0] BYTE_START = 8'hFA;
  localparam logic [7:0] BYTE_STOP  = 8'hFC;

  // Input action codes.
  localparam logic ACT_MIDI = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic REG_FADE_STEP       = 1'b0;
  localparam logic REG_CLOCKS_PER_BEAT = 1'b1;

  // Reset values.
  localparam logic [7:0]  FADE_STEP_RESET = 8'd6;
  localparam logic [5:0]  CPB_RESET       = 6'd24;
  localparam logic [15:0] DUTY_RESET      = 16'd32767;

  typedef struct packed {
    logic       action;
    logic [7:0] midi_byte;
  } mcbf_in_t;

  typedef struct packed {
    logic [15:0] duty_zero;
    logic [15:0] duty_one;
    logic [15:0] duty_two;
    logic        duty_updated;
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic        status_pin;
  } mcbf_out_t;

  typedef struct packed {
    logic [7:0]       beat_count;
    logic [2:0][5:0]  fade_index;
    logic [7:0]       tick_count;
    logic [2:0][15:0] duty_hold;
    logic             status_level;
  } mcbf_state_t;

  // Exponential fade curve; entries past the defined ones read as zero.
  function automatic logic [15:0] fade_curve(input logic [5:0] idx);
    logic [15:0] val;
    case (idx)
      6'd0:  val = 16'd65535;
      6'd1:  val = 16'd55937;
      6'd2:  val = 16'd46340;
      6'd3:  val = 16'd32767;
      6'd4:  val = 16'd27968;
      6'd5:  val = 16'd23170;
      6'd6:  val = 16'd16383;
      6'd7:  val = 16'd13984;
      6'd8:  val = 16'd11585;
      6'd9:  val = 16'd8192;
      6'd10: val = 16'd6992;
      6'd11: val = 16'd5792;
      6'd12: val = 16'd4096;
      6'd13: val = 16'd3496;
      6'd14: val = 16'd2896;
      6'd15: val = 16'd2047;
      6'd16: val = 16'd1747;
      6'd17: val = 16'd1448;
      6'd18: val = 16'd1024;
      6'd19: val = 16'd874;
      6'd20: val = 16'd724;
      6'd21: val = 16'd512;
      6'd22: val = 16'd437;
      6'd23: val = 16'd362;
      6'd24: val = 16'd256;
      6'd25: val = 16'd218;
      6'd26: val = 16'd181;
      6'd27: val = 16'd127;
      6'd28: val = 16'd108;
      6'd29: val = 16'd90;
      6'd30: val = 16'd64;
      6'd31: val = 16'd54;
      6'd32: val = 16'd45;
      6'd33: val = 16'd32;
      6'd34: val = 16'd27;
      6'd35: val = 16'd23;
      6'd36: val = 16'd16;
      6'd37: val = 16'd13;
      6'd38: val = 16'd11;
      6'd39: val = 16'd8;
      6'd40: val = 16'd7;
      6'd41: val = 16'd6;
      6'd42: val = 16'd4;
      6'd43: val = 16'd3;
      6'd44: val = 16'd3;
      6'd45: val = 16'd2;
      6'd46: val = 16'd1;
      6'd47: val = 16'd1;
      6'd48: val = 16'd1;
      default: val = 16'd0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/midi_clock_beat_led_fader.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// midi_clock_beat_led_fader
// Counts MIDI timing clocks to restart three staggered LED fades and steps
// the fades on millisecond ticks.
// ----------------------------------------------------------------------------
// Usage:
// Each input request is either a received MIDI byte (action 0) or a one
// millisecond tick (action 1) on the in_ valid/ready channel. Every request
// produces exactly one result on the out_ channel: the three LED duty values,
// a flag for a fresh duty load, the echoed byte (all bytes except the timing
// clock are echoed) and the run status pin level.
// An accepted request's result is registered in the output register if that
// is free or being taken, else in the skid stage. Throughput is one request
// per cycle while in_ready is high, set by the single registered pass of the
// update logic. The result register is backed by a one-entry skid stage, so
// a request is still taken while one result waits for out_ready; in_ready drops
// only when both are full. Configuration (fade step in ticks, clocks per
// beat) must be written through cfg_we/cfg_index/cfg_data while the block is
// idle; the block does not enforce this. Reset (synchronous, rst_n low) empties
// the output side, loads both registers with defaults, clears the counters
// and fade positions, sets every duty to half scale and raises the status pin.
// ----------------------------------------------------------------------------
module midi_clock_beat_led_fader (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcbf_pkg::mcbf_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcbf_pkg::mcbf_out_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);
  import mcbf_pkg::*;

  logic [7:0]  fade_step_r;
  logic [5:0]  cpb_r;
  mcbf_state_t state_r;
  mcbf_state_t state_nxt;
  mcbf_out_t   result;

  mcbf_out_t   out_data_r;
  mcbf_out_t   out_data_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  mcbf_out_t   skid_data_r;
  mcbf_out_t   skid_data_nxt;
  logic        skid_valid_r;
  logic        skid_valid_nxt;

  logic        in_fire;
  logic        out_take;

  assign in_ready  = ~skid_valid_r;
  assign in_fire   = in_valid & in_ready;
  assign out_take  = out_valid_r & out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mcbf_step u_step (
    .cur             (state_r),
    .req             (in_data),
    .fade_step_ticks (fade_step_r),
    .clocks_per_beat (cpb_r),
    .nxt             (state_nxt),
    .res             (result)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_step_r <= FADE_STEP_RESET;
      cpb_r       <= CPB_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FADE_STEP:       fade_step_r <= cfg_data;
        REG_CLOCKS_PER_BEAT: cpb_r       <= cfg_data[5:0];
        default:             fade_step_r <= fade_step_r;
      endcase
    end
  end

  // Block state advances once per accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.beat_count   <= 8'd0;
      state_r.fade_index   <= '0;
      state_r.tick_count   <= 8'd0;
      state_r.duty_hold    <= {3{DUTY_RESET}};
      state_r.status_level <= 1'b1;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Output register plus skid stage. The skid entry drains into the output
  // register first; a new result goes straight to the output register when
  // that register is free or being taken this cycle.
  always_comb begin
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    skid_data_nxt  = skid_data_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_take) begin
        out_data_nxt  = result;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = result;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // The skid stage only ever holds a result behind a waiting output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage full while output register empty");

  // Every accepted request leaves a result pending on the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted request produced no result");

  // Fade positions never run past the last curve entry.
  a_fade_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.fade_index[0] <= FADE_LAST) && (state_r.fade_index[1] <= FADE_LAST)
      && (state_r.fade_index[2] <= FADE_LAST))
    else $error("fade index beyond curve");

  // A taken result with nothing behind it empties the output.
  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !skid_valid_r && !in_fire) |=> !out_valid_r)
    else $error("output stayed valid after drain");

endmodule
`default_nettype wire

// ===== rtl/mcbf_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mcbf_step
// Next-state and result logic for one request: beat counting, fade stepping,
// byte echo and the run status pin.
// ----------------------------------------------------------------------------
module mcbf_step (
  input  mcbf_pkg::mcbf_state_t cur,
  input  mcbf_pkg::mcbf_in_t    req,
  input  logic [7:0]            fade_step_ticks,
  input  logic [5:0]            clocks_per_beat,
  output mcbf_pkg::mcbf_state_t nxt,
  output mcbf_pkg::mcbf_out_t   res
);
  import mcbf_pkg::*;

  logic [7:0] beat_inc;
  logic [7:0] cpb1;
  logic [7:0] cpb2;
  logic [7:0] cpb3;
  logic [7:0] cpb4;
  logic       cpb_nz;
  logic [7:0] tick_inc;
  logic       fade_due;
  logic       updated;
  logic       echo;

  assign beat_inc = cur.beat_count + 8'd1;
  assign tick_inc = cur.tick_count + 8'd1;
  assign cpb1     = {2'b00, clocks_per_beat};
  assign cpb2     = {1'b0, clocks_per_beat, 1'b0};
  assign cpb3     = cpb1 + cpb2;
  assign cpb4     = {clocks_per_beat, 2'b00};
  assign cpb_nz   = (clocks_per_beat != 6'd0);
  assign fade_due = (tick_inc >= fade_step_ticks);

  always_comb begin
    nxt     = cur;
    updated = 1'b0;
    echo    = 1'b0;
    if (req.action == ACT_TICK) begin
      nxt.tick_count = tick_inc;
      if (fade_due) begin
        updated        = 1'b1;
        nxt.tick_count = 8'd0;
        for (int i = 0; i < 3; i++) begin
          nxt.duty_hold[i] = fade_curve(cur.fade_index[i]);
          if (cur.fade_index[i] < FADE_LAST) begin
            nxt.fade_index[i] = cur.fade_index[i] + 6'd1;
          end
        end
      end
    end else if (req.midi_byte == BYTE_CLOCK) begin
      // A new cycle starts all three fades from the top of the curve.
      if (cur.beat_count == 8'd0) begin
        nxt.fade_index = '0;
      end
      nxt.beat_count = beat_inc;
      if (cpb_nz) begin
        if (beat_inc == cpb1) nxt.fade_index[0] = 6'd0;
        if (beat_inc == cpb2) nxt.fade_index[1] = 6'd0;
        if (beat_inc == cpb3) nxt.fade_index[2] = 6'd0;
        if (beat_inc == cpb4) nxt.beat_count = 8'd0;
      end
    end else begin
      echo = 1'b1;
      if (req.midi_byte == BYTE_START) begin
        nxt.status_level = ~cur.status_level;
        nxt.beat_count   = 8'd0;
      end else if (req.midi_byte == BYTE_STOP) begin
        nxt.status_level = 1'b0;
        nxt.beat_count   = 8'd0;
      end
    end
  end

  always_comb begin
    res.duty_zero    = nxt.duty_hold[0];
    res.duty_one     = nxt.duty_hold[1];
    res.duty_two     = nxt.duty_hold[2];
    res.duty_updated = updated;
    res.echo_valid   = echo;
    res.echo_byte    = echo ? req.midi_byte : 8'd0;
    res.status_pin   = nxt.status_level;
  end

endmodule
`default_nettype wire

// ===== test/midi_clock_beat_led_fader_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_clock_beat_led_fader_checker
// Watches both channels of the fader. It keeps its own copy of the beat,
// fade and status state, works out the result of every accepted request and
// compares each accepted result, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------
module midi_clock_beat_led_fader_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mcbf_pkg::mcbf_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mcbf_pkg::mcbf_out_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  output int unsigned         fail_count,
  output int unsigned         outstanding
);
  import mcbf_pkg::*;

  // Exponential fade curve; positions past the defined entries read as zero.
  logic [15:0] curve_tab [64] = '{
    16'd65535, 16'd55937, 16'd46340, 16'd32767, 16'd27968, 16'd23170,
    16'd16383, 16'd13984, 16'd11585, 16'd8192,  16'd6992,  16'd5792,
    16'd4096,  16'd3496,  16'd2896,  16'd2047,  16'd1747,  16'd1448,
    16'd1024,  16'd874,   16'd724,   16'd512,   16'd437,   16'd362,
    16'd256,   16'd218,   16'd181,   16'd127,   16'd108,   16'd90,
    16'd64,    16'd54,    16'd45,    16'd32,    16'd27,    16'd23,
    16'd16,    16'd13,    16'd11,    16'd8,     16'd7,     16'd6,
    16'd4,     16'd3,     16'd3,     16'd2,     16'd1,     16'd1,
    16'd1,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0,
    16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0,
    16'd0,     16'd0,     16'd0,     16'd0
  };

  logic [7:0]  step_ticks;
  logic [5:0]  clk_per_beat;
  logic [7:0]  beat_cnt;
  logic [5:0]  fade_pos [3];
  logic [7:0]  ms_cnt;
  logic [15:0] duty_level [3];
  logic        run_pin;

  mcbf_out_t   led_result_q [$];
  int unsigned err_total;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    err_total   = 0;
  end

  task automatic clear_fader_state();
    step_ticks   = FADE_STEP_RESET;
    clk_per_beat = CPB_RESET;
    beat_cnt     = '0;
    ms_cnt       = '0;
    run_pin      = 1'b1;
    for (int i = 0; i < 3; i++) begin
      fade_pos[i]   = '0;
      duty_level[i] = DUTY_RESET;
    end
  endtask

  // Advances the fader state by one request and returns the result it causes.
  function automatic mcbf_out_t fader_next_result(input mcbf_in_t req);
    mcbf_out_t res;
    int        cpb;
    res = '0;
    cpb = int'(clk_per_beat);
    if (req.action == ACT_TICK) begin
      ms_cnt = ms_cnt + 8'd1;
      if (ms_cnt >= step_ticks) begin
        for (int i = 0; i < 3; i++) begin
          duty_level[i] = curve_tab[fade_pos[i]];
          if (fade_pos[i] < FADE_LAST)
            fade_pos[i] = fade_pos[i] + 6'd1;
        end
        ms_cnt = '0;
        res.duty_updated = 1'b1;
      end
    end else if (req.midi_byte == BYTE_CLOCK) begin
      // All fades restart together at the top of the cycle.
      if (beat_cnt == 8'd0) begin
        for (int i = 0; i < 3; i++)
          fade_pos[i] = '0;
      end
      beat_cnt = beat_cnt + 8'd1;
      if (cpb != 0) begin
        if (int'(beat_cnt) == cpb)
          fade_pos[0] = '0;
        if (int'(beat_cnt) == 2 * cpb)
          fade_pos[1] = '0;
        if (int'(beat_cnt) == 3 * cpb)
          fade_pos[2] = '0;
        if (int'(beat_cnt) == 4 * cpb)
          beat_cnt = '0;
      end
    end else begin
      if (req.midi_byte == BYTE_START) begin
        run_pin  = ~run_pin;
        beat_cnt = '0;
      end else if (req.midi_byte == BYTE_STOP) begin
        run_pin  = 1'b0;
        beat_cnt = '0;
      end
      res.echo_valid = 1'b1;
      res.echo_byte  = req.midi_byte;
    end
    res.duty_zero  = duty_level[0];
    res.duty_one   = duty_level[1];
    res.duty_two   = duty_level[2];
    res.status_pin = run_pin;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      err_total++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    mcbf_out_t want;
    if (!rst_n) begin
      clear_fader_state();
      led_result_q.delete();
      outstanding <= 0;
    end else begin
      // A result leaving at this edge belongs to an earlier request, so it is
      // checked before the request taken at the same edge is predicted.
      if (out_valid && out_ready) begin
        if (led_result_q.size() == 0) begin
          err_total++;
          $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
        end else begin
          want = led_result_q.pop_front();
          check_field("duty_zero", want.duty_zero, out_data.duty_zero);
          check_field("duty_one", want.duty_one, out_data.duty_one);
          check_field("duty_two", want.duty_two, out_data.duty_two);
          check_field("duty_updated", 16'(want.duty_updated), 16'(out_data.duty_updated));
          check_field("echo_valid", 16'(want.echo_valid), 16'(out_data.echo_valid));
          check_field("echo_byte", 16'(want.echo_byte), 16'(out_data.echo_byte));
          check_field("status_pin", 16'(want.status_pin), 16'(out_data.status_pin));
        end
      end
      if (in_valid && in_ready)
        led_result_q.push_back(fader_next_result(in_data));
      if (cfg_we) begin
        if (cfg_index == REG_FADE_STEP)
          step_ticks = cfg_data;
        else
          clk_per_beat = cfg_data[5:0];
      end
      outstanding <= led_result_q.size();
    end
    fail_count <= err_total;
  end

endmodule

// ===== test/midi_clock_beat_led_fader_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_clock_beat_led_fader_tb
// Drives MIDI bytes and millisecond ticks into the fader under bursty traffic
// and a stalling receiver, rewrites both registers between phases, and gives
// the verdict from the failure count of the checker that sits beside it.
// ----------------------------------------------------------------------------
module midi_clock_beat_led_fader_tb;
  import mcbf_pkg::*;

  // The slowest correct run stays far below this many cycles.
  localparam int unsigned CYCLE_LIMIT = 300000;
  // Length of each long receiver hold-off that fills the skid stage.
  localparam int unsigned HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  mcbf_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  mcbf_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_FADE_STEP;
  logic [7:0]  cfg_data = '0;

  int unsigned fail_count;
  int unsigned outstanding;

  // Sender burst bookkeeping and the hold-off requests for the receiver.
  int unsigned burst_left = 0;
  int unsigned hold_req_cnt = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned cycle_cnt = 0;

  // The clock runs with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  midi_clock_beat_led_fader dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  midi_clock_beat_led_fader_checker checker_inst (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // The receiver follows a pattern of its own, picked by rx_cycle[8:7]:
  // always ready, coin flip, mostly stalled, mostly ready. A hold-off request
  // from the stimulus overrides the pattern for a long stretch so that the
  // result register and the skid stage both fill and in_ready drops while
  // the sender keeps offering requests.
  always @(posedge clk) begin
    rx_cycle++;
    if (hold_served != hold_req_cnt) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_cycle[8:7])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= 1'($urandom_range(0, 1));
        2'd2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // A run that stalls forever, or leaves an expected result behind, ends here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** midi_clock_beat_led_fader: FAILED **");
      $finish;
    end
  end

  // Offers one request and returns at the edge that accepts it. Requests come
  // in bursts; a gap of random length opens before each new burst. Valid is
  // only lowered when a real gap follows, so it never drops and rises again
  // within one time step.
  task automatic offer_request(input logic act, input logic [7:0] byte_val);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid          <= 1'b1;
    in_data.action    <= act;
    in_data.midi_byte <= byte_val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_clocks(input int unsigned count);
    repeat (count) offer_request(ACT_MIDI, BYTE_CLOCK);
  endtask

  task automatic send_ticks(input int unsigned count);
    repeat (count) offer_request(ACT_TICK, 8'($urandom));
  endtask

  // Stops offering and waits until every expected result has come out. The
  // first edge lets the count from the last accepted request settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    burst_left = 0;
  endtask

  // Writes both registers while the block is idle. The clocks per beat value
  // is passed at full port width so that the upper bits get exercised.
  task automatic set_registers(input logic [7:0] fade_step, input logic [7:0] beat_len);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FADE_STEP;
    cfg_data  <= fade_step;
    @(posedge clk);
    cfg_index <= REG_CLOCKS_PER_BEAT;
    cfg_data  <= beat_len;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // One random request. Most traffic looks like a real MIDI stream: timing
  // clocks interleaved with millisecond ticks, with the odd start, stop or
  // unrelated byte as noise.
  task automatic offer_random_request();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      offer_request(ACT_MIDI, BYTE_CLOCK);
    else if (pick < 75)
      offer_request(ACT_TICK, 8'($urandom));
    else if (pick < 83)
      offer_request(ACT_MIDI, BYTE_START);
    else if (pick < 88)
      offer_request(ACT_MIDI, BYTE_STOP);
    else
      offer_request(ACT_MIDI, 8'($urandom));
  endtask

  initial begin : stimulus
    logic [7:0] fade_step;
    logic [7:0] beat_len;
    int unsigned pick;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset defaults: echoed bytes at both extremes,
    // start twice to see the status pin toggle, stop, one clock, and six
    // ticks so that the sixth loads the duties.
    offer_request(ACT_MIDI, 8'h00);
    offer_request(ACT_MIDI, 8'hFF);
    offer_request(ACT_MIDI, 8'h7F);
    offer_request(ACT_MIDI, BYTE_START);
    offer_request(ACT_MIDI, BYTE_START);
    offer_request(ACT_MIDI, BYTE_STOP);
    offer_request(ACT_MIDI, BYTE_CLOCK);
    offer_request(ACT_MIDI, 8'hF9);
    offer_request(ACT_TICK, 8'h00);
    offer_request(ACT_TICK, 8'hFF);
    send_ticks(4);

    // A zero fade step loads the duties on every tick, and zero clocks per
    // beat leaves only the clearing at count zero.
    set_registers(8'd0, 8'd0);
    send_ticks(3);
    send_clocks(3);
    send_ticks(2);

    // The largest fade step, and a clocks per beat value whose upper bits
    // fall away so that the field reads as its maximum.
    set_registers(8'd255, 8'hFF);
    send_clocks(3);
    send_ticks(3);

    // Count beyond the cycle: run the count high with the longest beat, then
    // shorten the beat so that the count has to wrap around through 255.
    set_registers(8'd2, 8'd63);
    send_clocks(200);
    set_registers(8'd2, 8'd10);
    repeat (40) begin
      send_clocks(2);
      send_ticks(1);
    end

    // Deep into the curve: every fade walks to its last entry and holds.
    set_registers(8'd1, 8'd24);
    send_ticks(60);

    // Random phases with a fresh setting each time; two of them begin with a
    // long receiver hold-off.
    for (int phase = 0; phase < 10; phase++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)
        fade_step = 8'd0;
      else if (pick == 1)
        fade_step = 8'd255;
      else
        fade_step = 8'($urandom_range(1, 8));
      pick = $urandom_range(0, 9);
      if (pick == 0)
        beat_len = 8'd63;
      else if (pick == 1)
        beat_len = 8'($urandom);
      else if (pick == 2)
        beat_len = 8'd24;
      else
        beat_len = 8'($urandom_range(1, 6));
      set_registers(fade_step, beat_len);
      if (phase == 2 || phase == 6)
        hold_req_cnt++;
      repeat (100) offer_random_request();
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("** midi_clock_beat_led_fader: PASSED **");
    else
      $display("** midi_clock_beat_led_fader: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mcbf_pkg.sv
rtl/mcbf_step.sv
rtl/midi_clock_beat_led_fader.sv
test/midi_clock_beat_led_fader_checker.sv
test/midi_clock_beat_led_fader_tb.sv
